// File: rtl/core/dxt_block_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// DXT block decoder assertion macros
// Shared property wrappers for the checker that watches the decoder ports.
// ----------------------------------------------------------------------------
`ifndef DXT_BLOCK_DECODER_TOP_MACROS_SVH
`define DXT_BLOCK_DECODER_TOP_MACROS_SVH

// Clocked property, switched off while reset is held.
`define DXT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be seen.
`define DXT_ASSERT_NEVER(lbl, cond, msg) \
	`DXT_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/core/dxt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DXT decoder package
// Types, codes and constant-divide helpers shared by the decoder modules.
// ----------------------------------------------------------------------------
package dxt_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;

	// Block formats.
	localparam logic [1:0] FMT_DXT1 = 2'd0;
	localparam logic [1:0] FMT_DXT3 = 2'd1;
	localparam logic [1:0] FMT_DXT5 = 2'd2;

	localparam int PIX_CNT_W = 4;
	localparam int ADDR_W    = 24;

	typedef struct packed {
		logic [1:0] fmt;
		logic       trans_en;
	} dxt_cfg_t;

	// One decoded block as it waits between the front and back ends.
	typedef struct packed {
		logic [3:0][23:0]  pal;
		logic [7:0][7:0]   atab;
		logic [31:0]       cidx;
		logic [63:0]       abits;
		logic [1:0]        fmt;
		logic              trans;
		logic [ADDR_W-1:0] base;
	} dxt_entry_t;

	// RGB565 to packed {B,G,R} eight bits each, by bit replication.
	function automatic logic [23:0] widen565(input logic [15:0] c);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		r = {c[15:11], c[15:13]};
		g = {c[10:5], c[10:9]};
		b = {c[4:0], c[4:2]};
		return {b, g, r};
	endfunction

	// x / 3 for x below 768.
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [21:0] m;
		m = 22'(x) * 22'd2731;
		return m[20:13];
	endfunction

	// x / 7 for x below 1792.
	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [21:0] m;
		m = 22'(x) * 22'd2341;
		return m[21:14];
	endfunction

	// x / 5 for x below 1280.
	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [21:0] m;
		m = 22'(x) * 22'd1639;
		return m[20:13];
	endfunction

endpackage

// File: rtl/core/dxt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DXT decoder front end
// Takes blocks, builds colour palette, alpha table and base address.
// ----------------------------------------------------------------------------
module dxt_front #(
	parameter int WIDTH_W = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [63:0]         color_block,
	input  logic [63:0]         alpha_block,
	input  logic [11:0]         block_x,
	input  logic [11:0]         block_y,
	input  dxt_pkg::dxt_cfg_t   cfg,
	input  logic [WIDTH_W-1:0]  width,
	output logic                push,
	output dxt_pkg::dxt_entry_t push_data,
	input  logic                full
);
	import dxt_pkg::*;

	localparam int PROD_W = 12 + WIDTH_W;

	// Stage 1: registered request.
	logic        s1_v_q;
	logic [63:0] color_s1;
	logic [63:0] alpha_s1;
	logic [11:0] bx_s1;
	logic [11:0] by_s1;

	// Stage 2: numerators ready for the constant dividers.
	logic                 s2_v_q;
	logic [1:0][23:0]     pal01_s2;
	logic [2:0][9:0]      n2_s2;
	logic [2:0][9:0]      n3_s2;
	logic                 four_s2;
	logic [7:0]           a0_s2;
	logic [7:0]           a1_s2;
	logic                 gt_s2;
	logic [5:0][10:0]     anum_s2;
	logic [31:0]          cidx_s2;
	logic [63:0]          abits_s2;
	logic [1:0]           fmt_s2;
	logic                 trans_s2;
	logic [ADDR_W-1:0]    base_s2;

	logic                 s1_go;
	logic                 in_fire;
	logic [1:0]           fmt_c;
	logic [15:0]          e0;
	logic [15:0]          e1;
	logic                 four_c;
	logic [23:0]          w0;
	logic [23:0]          w1;
	logic [2:0][9:0]      n2_c;
	logic [2:0][9:0]      n3_c;
	logic [7:0]           a0_c;
	logic [7:0]           a1_c;
	logic                 gt_c;
	logic [5:0][10:0]     anum_c;
	logic [PROD_W-1:0]    prod_c;
	logic [ADDR_W-1:0]    base_c;
	logic [7:0]           pa;
	logic [7:0]           pb;

	assign push     = s2_v_q && !full;
	assign s1_go    = !s2_v_q || push;
	assign in_ready = !s1_v_q || s1_go;
	assign in_fire  = in_valid && in_ready;

	// Unused format code decodes as DXT1.
	assign fmt_c = (cfg.fmt == FMT_DXT3 || cfg.fmt == FMT_DXT5) ? cfg.fmt : FMT_DXT1;

	always_comb begin
		e0     = color_s1[15:0];
		e1     = color_s1[31:16];
		four_c = (fmt_c == FMT_DXT5) || (e0 > e1);
		w0     = widen565(e0);
		w1     = widen565(e1);
		for (int c = 0; c < 3; c++) begin
			pa = w0[8*c +: 8];
			pb = w1[8*c +: 8];
			if (four_c) begin
				n2_c[c] = ({2'b00, pa} << 1) + {2'b00, pb};
				n3_c[c] = {2'b00, pa} + ({2'b00, pb} << 1);
			end else begin
				n2_c[c] = 10'(({1'b0, pa} + {1'b0, pb}) >> 1);
				n3_c[c] = 10'd0;
			end
		end
		a0_c = alpha_s1[7:0];
		a1_c = alpha_s1[15:8];
		gt_c = a0_c > a1_c;
		for (int k = 1; k <= 6; k++) begin
			if (gt_c) begin
				anum_c[k-1] = 11'(7 - k) * {3'b000, a0_c} + 11'(k) * {3'b000, a1_c};
			end else if (k <= 4) begin
				anum_c[k-1] = 11'(5 - k) * {3'b000, a0_c} + 11'(k) * {3'b000, a1_c};
			end else begin
				anum_c[k-1] = 11'd0;
			end
		end
		prod_c = PROD_W'(by_s1) * PROD_W'(width);
		base_c = prod_c[ADDR_W-1:0] + ADDR_W'(bx_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_v_q <= 1'b1;
			end else if (s1_go) begin
				s1_v_q <= 1'b0;
			end
			if (s1_v_q && s1_go) begin
				s2_v_q <= 1'b1;
			end else if (push) begin
				s2_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			color_s1 <= color_block;
			alpha_s1 <= alpha_block;
			bx_s1    <= block_x;
			by_s1    <= block_y;
		end
		if (s1_v_q && s1_go) begin
			pal01_s2 <= {w1, w0};
			n2_s2    <= n2_c;
			n3_s2    <= n3_c;
			four_s2  <= four_c;
			a0_s2    <= a0_c;
			a1_s2    <= a1_c;
			gt_s2    <= gt_c;
			anum_s2  <= anum_c;
			cidx_s2  <= color_s1[63:32];
			abits_s2 <= alpha_s1;
			fmt_s2   <= fmt_c;
			trans_s2 <= !four_c && cfg.trans_en;
			base_s2  <= base_c;
		end
	end

	// Final divides by three, five and seven as reciprocal multiplies.
	always_comb begin
		push_data.pal[0] = pal01_s2[0];
		push_data.pal[1] = pal01_s2[1];
		for (int c = 0; c < 3; c++) begin
			if (four_s2) begin
				push_data.pal[2][8*c +: 8] = div3(n2_s2[c]);
				push_data.pal[3][8*c +: 8] = div3(n3_s2[c]);
			end else begin
				push_data.pal[2][8*c +: 8] = n2_s2[c][7:0];
				push_data.pal[3][8*c +: 8] = 8'd0;
			end
		end
		push_data.atab[0] = a0_s2;
		push_data.atab[1] = a1_s2;
		for (int k = 1; k <= 6; k++) begin
			if (gt_s2) begin
				push_data.atab[k+1] = div7(anum_s2[k-1]);
			end else if (k <= 4) begin
				push_data.atab[k+1] = div5(anum_s2[k-1]);
			end else if (k == 5) begin
				push_data.atab[k+1] = 8'd0;
			end else begin
				push_data.atab[k+1] = 8'd255;
			end
		end
		push_data.cidx  = cidx_s2;
		push_data.abits = abits_s2;
		push_data.fmt   = fmt_s2;
		push_data.trans = trans_s2;
		push_data.base  = base_s2;
	end

endmodule

// File: rtl/core/dxt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DXT decoder block queue
// Two-entry queue of decoded blocks between the front and back ends.
// ----------------------------------------------------------------------------
module dxt_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dxt_pkg::dxt_entry_t din,
	output logic                full,
	input  logic                pop,
	output dxt_pkg::dxt_entry_t dout,
	output logic                empty
);
	import dxt_pkg::*;

	dxt_entry_t mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

endmodule

// File: rtl/core/dxt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DXT decoder back end
// Walks a queued block into the output register, one pixel per unstalled cycle.
// ----------------------------------------------------------------------------
module dxt_back #(
	parameter int WIDTH_W = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dxt_pkg::dxt_entry_t head,
	input  logic                head_valid,
	output logic                pop,
	input  logic [WIDTH_W-1:0]  width,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         pixel_rgba,
	output logic [23:0]         pixel_address,
	output logic                last_pixel,
	output logic                zero_alpha_seen,
	output logic                partial_alpha_seen
);
	import dxt_pkg::*;

	localparam int ROW_W = WIDTH_W + 2;

	logic [PIX_CNT_W-1:0] cnt_q;
	logic                 zero_q;
	logic                 part_q;
	logic                 out_valid_q;

	logic                 fire;
	logic                 last_c;
	logic [1:0]           ci;
	logic [5:0]           apos;
	logic [2:0]           aidx;
	logic [3:0]           nib;
	logic [7:0]           alpha;
	logic                 zero_now;
	logic                 part_now;
	logic [ROW_W-1:0]     row_off;
	logic [ADDR_W-1:0]    addr_c;

	assign out_valid = out_valid_q;
	assign fire      = head_valid && (!out_valid_q || out_ready);
	assign last_c    = cnt_q == PIX_CNT_W'(15);
	assign pop       = fire && last_c;

	always_comb begin
		ci   = head.cidx[{cnt_q, 1'b0} +: 2];
		apos = 6'd16 + 6'(cnt_q) * 6'd3;
		aidx = head.abits[apos +: 3];
		nib  = head.abits[{cnt_q, 2'b00} +: 4];
		unique case (head.fmt)
			FMT_DXT5: alpha = head.atab[aidx];
			FMT_DXT3: alpha = {nib, nib};
			default:  alpha = 8'd255;
		endcase
		if (head.trans && ci == 2'd3) begin
			alpha = 8'd0;
		end
		zero_now = alpha == 8'd0;
		part_now = alpha != 8'd0 && alpha != 8'd255;
		row_off  = ROW_W'(cnt_q[3:2]) * ROW_W'(width);
		addr_c   = head.base + ADDR_W'(row_off) + ADDR_W'(cnt_q[1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			zero_q      <= 1'b0;
			part_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				cnt_q       <= cnt_q + PIX_CNT_W'(1);
				zero_q      <= last_c ? 1'b0 : (zero_q || zero_now);
				part_q      <= last_c ? 1'b0 : (part_q || part_now);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pixel_rgba         <= {alpha, head.pal[ci]};
			pixel_address      <= addr_c;
			last_pixel         <= last_c;
			zero_alpha_seen    <= last_c && (zero_q || zero_now);
			partial_alpha_seen <= last_c && (part_q || part_now);
		end
	end

endmodule

// File: rtl/core/dxt_block_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DXT block decoder
// Decompresses DXT1, DXT3 and DXT5 4x4 blocks into sixteen RGBA8888 pixels.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake              Carries
//   -------  ---------------------  -------------------------------------------
//   in       in_valid / in_ready    color_block, alpha_block, block_x, block_y
//   out      out_valid / out_ready  pixel_rgba, pixel_address, last_pixel, flags
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each block gives sixteen pixels, one per cycle while a block is queued and
// the output is not stalled, from the single output register of the back end.
// A request passes the two front-end stages and the queue to reach it. Reset
// clears the pipeline valids, the queue and the configuration registers; no
// clearing pass is needed. When out_ready is low the pixel is held, and the
// front end takes requests until its two stages and the two-entry queue fill.
//
module dxt_block_decoder_top #(
	parameter int MAX_IMAGE_DIM = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [63:0]                    color_block,
	input  logic [63:0]                    alpha_block,
	input  logic [11:0]                    block_x,
	input  logic [11:0]                    block_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [31:0]                    pixel_rgba,
	output logic [23:0]                    pixel_address,
	output logic                           last_pixel,
	output logic                           zero_alpha_seen,
	output logic                           partial_alpha_seen,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dxt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dxt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dxt_pkg::*;

	// The width register must hold the reset value even where that exceeds
	// what a configuration write can store.
	localparam int DIM_W = $clog2(MAX_IMAGE_DIM + 1);
	localparam int WW    = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;

	logic [1:0]    block_format_q;
	logic          trans_en_q;
	logic [WW-1:0] image_width_q;
	logic [WW-1:0] width_eff;
	dxt_cfg_t      cfg;

	logic          push;
	logic          full;
	logic          pop;
	logic          empty;
	dxt_entry_t    push_data;
	dxt_entry_t    head;

	// The configuration port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_format_q <= FMT_DXT1;
			trans_en_q     <= 1'b0;
			image_width_q  <= WW'(MAX_IMAGE_DIM);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BLOCK_FORMAT: block_format_q <= cfg_data[1:0];
				CFG_TRANSPARENT:  trans_en_q     <= cfg_data[0];
				CFG_IMAGE_WIDTH:  image_width_q  <= WW'(cfg_data);
				default: ;
			endcase
		end
	end

	// A stride wider than the largest image is used as the largest image.
	assign width_eff = (image_width_q > WW'(MAX_IMAGE_DIM)) ? WW'(MAX_IMAGE_DIM)
		: image_width_q;

	assign cfg.fmt      = block_format_q;
	assign cfg.trans_en = trans_en_q;

	// Front end: registers the request, then builds the palette, the alpha
	// table and the block's base address over two stages.
	dxt_front #(
		.WIDTH_W (WW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.color_block (color_block),
		.alpha_block (alpha_block),
		.block_x     (block_x),
		.block_y     (block_y),
		.cfg         (cfg),
		.width       (width_eff),
		.push        (push),
		.push_data   (push_data),
		.full        (full)
	);

	// Decoded blocks wait here so that a stalled output does not stop the
	// front end at once.
	dxt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.full   (full),
		.pop    (pop),
		.dout   (head),
		.empty  (empty)
	);

	// Back end: picks palette entry and alpha for each pixel in turn and
	// releases the queue entry with the sixteenth pixel.
	dxt_back #(
		.WIDTH_W (WW)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.head               (head),
		.head_valid         (!empty),
		.pop                (pop),
		.width              (width_eff),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.pixel_rgba         (pixel_rgba),
		.pixel_address      (pixel_address),
		.last_pixel         (last_pixel),
		.zero_alpha_seen    (zero_alpha_seen),
		.partial_alpha_seen (partial_alpha_seen)
	);

endmodule

// File: rtl/core/dxt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DXT decoder port checker
// Watches the decoder ports for framing and ordering slips.
// ----------------------------------------------------------------------------
`include "dxt_block_decoder_top_macros.svh"

module dxt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] pixel_rgba,
	input  logic [23:0] pixel_address,
	input  logic        last_pixel,
	input  logic        zero_alpha_seen,
	input  logic        partial_alpha_seen
);

	logic [3:0] pix_q;
	logic [3:0] blocks_q;
	logic       in_acc;
	logic       out_acc;
	logic       blk_done;

	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;
	assign blk_done = out_acc && last_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q    <= 4'd0;
			blocks_q <= 4'd0;
		end else begin
			if (out_acc) begin
				pix_q <= pix_q + 4'd1;
			end
			if (in_acc && !blk_done) begin
				blocks_q <= blocks_q + 4'd1;
			end else if (blk_done && !in_acc) begin
				blocks_q <= blocks_q - 4'd1;
			end
		end
	end

	`DXT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(pixel_rgba) && $stable(pixel_address) && $stable(last_pixel), "pixel changed while stalled")
	`DXT_ASSERT(a_last_frame, out_valid |-> (last_pixel == (pix_q == 4'd15)), "last pixel flag out of step")
	`DXT_ASSERT_NEVER(a_flags_last, out_valid && !last_pixel && (zero_alpha_seen || partial_alpha_seen), "alpha flags away from last pixel")
	`DXT_ASSERT_NEVER(a_no_orphan, out_valid && blocks_q == 4'd0, "pixel without an accepted block")

endmodule

bind dxt_block_decoder_top dxt_checker u_dxt_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DXT block decoder testbench
// Sends compressed 4x4 blocks in DXT1, DXT3 and DXT5 form under a range of
// format, transparency and stride settings. Every pixel that comes back is
// compared with a decode computed here from the same block and settings.
// Both channels are throttled at random.
// ----------------------------------------------------------------------------
module testbench;

	import dxt_pkg::*;

	localparam int MAX_DIM = 4096;

	// Quiet cycles with no request moving on any channel before the run is abandoned.
	localparam int STALL_LIMIT = 4000;

	// Cycles allowed after the last pixel before the block counts as idle.
	localparam int SETTLE_CYCLES = 8;

	// The spare format code, which the block treats as DXT1.
	localparam logic [1:0] FMT_SPARE = 2'd3;

	// One decoded pixel as it should leave the block.
	typedef struct packed {
		logic [31:0] rgba;
		logic [23:0] addr;
		logic        last;
		logic        zero;
		logic        part;
	} pixel_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [63:0]           color_block = '0;
	logic [63:0]           alpha_block = '0;
	logic [11:0]           block_x     = '0;
	logic [11:0]           block_y     = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [31:0]           pixel_rgba;
	logic [23:0]           pixel_address;
	logic                  last_pixel;
	logic                  zero_alpha_seen;
	logic                  partial_alpha_seen;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;

	// Our copy of the configuration registers, at their reset values.
	logic [1:0]  cfg_format = FMT_DXT1;
	logic        cfg_trans  = 1'b0;
	logic [12:0] cfg_width  = 13'd4096;

	// Pixels that the accepted blocks still owe us, oldest first.
	pixel_t pending_pixels[$];

	int errors        = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles  = 0;

	dxt_block_decoder_top #(
		.MAX_IMAGE_DIM(MAX_DIM)
	) dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.color_block       (color_block),
		.alpha_block       (alpha_block),
		.block_x           (block_x),
		.block_y           (block_y),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.pixel_rgba        (pixel_rgba),
		.pixel_address     (pixel_address),
		.last_pixel        (last_pixel),
		.zero_alpha_seen   (zero_alpha_seen),
		.partial_alpha_seen(partial_alpha_seen),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bit replication from five and six bits up to eight.
	function automatic logic [7:0] widen5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	// Decodes one block under the current settings and queues its sixteen pixels.
	function automatic void decode_block(input logic [63:0] cb, input logic [63:0] ab,
			input logic [11:0] bx, input logic [11:0] by);
		logic [1:0]  fmt;
		int unsigned stride;
		logic [15:0] e0;
		logic [15:0] e1;
		logic [7:0]  pal[4][3];
		logic [7:0]  atab[8];
		int unsigned a0;
		int unsigned a1;
		int unsigned ci;
		logic [7:0]  alpha;
		logic [31:0] addr;
		bit          four;
		bit          zero_seen;
		bit          part_seen;
		pixel_t      px;
		fmt = (cfg_format == FMT_DXT3 || cfg_format == FMT_DXT5) ? cfg_format : FMT_DXT1;
		stride = (32'(cfg_width) > MAX_DIM) ? MAX_DIM : 32'(cfg_width);
		e0 = cb[15:0];
		e1 = cb[31:16];
		four = (fmt == FMT_DXT5) || (e0 > e1);
		pal[0][0] = widen5(e0[15:11]);
		pal[0][1] = widen6(e0[10:5]);
		pal[0][2] = widen5(e0[4:0]);
		pal[1][0] = widen5(e1[15:11]);
		pal[1][1] = widen6(e1[10:5]);
		pal[1][2] = widen5(e1[4:0]);
		for (int c = 0; c < 3; c++) begin
			if (four) begin
				pal[2][c] = 8'((2 * pal[0][c] + pal[1][c]) / 3);
				pal[3][c] = 8'((pal[0][c] + 2 * pal[1][c]) / 3);
			end else begin
				pal[2][c] = 8'((pal[0][c] + pal[1][c]) / 2);
				pal[3][c] = 8'd0;
			end
		end
		for (int k = 0; k < 8; k++) atab[k] = 8'd0;
		if (fmt == FMT_DXT5) begin
			a0 = 32'(ab[7:0]);
			a1 = 32'(ab[15:8]);
			atab[0] = 8'(a0);
			atab[1] = 8'(a1);
			if (a0 > a1) begin
				for (int unsigned k = 1; k <= 6; k++)
					atab[k + 1] = 8'(((7 - k) * a0 + k * a1) / 7);
			end else begin
				for (int unsigned k = 1; k <= 4; k++)
					atab[k + 1] = 8'(((5 - k) * a0 + k * a1) / 5);
				atab[6] = 8'd0;
				atab[7] = 8'd255;
			end
		end
		zero_seen = 1'b0;
		part_seen = 1'b0;
		for (int p = 0; p < 16; p++) begin
			ci = 32'(cb[32 + 2 * p +: 2]);
			if (fmt == FMT_DXT5) begin
				alpha = atab[ab[16 + 3 * p +: 3]];
			end else begin
				alpha = (fmt == FMT_DXT3) ? 8'(ab[4 * p +: 4] * 17) : 8'd255;
				if (!four && ci == 3 && cfg_trans) alpha = 8'd0;
			end
			if (alpha == 8'd0) zero_seen = 1'b1;
			else if (alpha != 8'd255) part_seen = 1'b1;
			addr = 32'((bx + p % 4) + (by + p / 4) * stride);
			px.rgba = {alpha, pal[ci][2], pal[ci][1], pal[ci][0]};
			px.addr = addr[23:0];
			px.last = (p == 15);
			px.zero = (p == 15) && zero_seen;
			px.part = (p == 15) && part_seen;
			pending_pixels.push_back(px);
		end
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Offers one block, with a random gap first, and waits for the request to
	// be taken. Valid is left high so that a following block can go straight on.
	task automatic send_block(input logic [63:0] cb, input logic [63:0] ab,
			input logic [11:0] bx, input logic [11:0] by);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		color_block <= cb;
		alpha_block <= ab;
		block_x     <= bx;
		block_y     <= by;
		do @(posedge clk); while (!in_ready);
		decode_block(cb, ab, bx, by);
	endtask

	// Stops sending and waits until every owed pixel has come out.
	task automatic drain;
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
	endtask

	// Writes all three registers once the block has gone quiet.
	task automatic set_config(input logic [1:0] fmt, input logic trans,
			input logic [12:0] width);
		logic [CFG_IDX_W-1:0]  idx[3];
		logic [CFG_DATA_W-1:0] val[3];
		idx[0] = CFG_BLOCK_FORMAT;
		idx[1] = CFG_TRANSPARENT;
		idx[2] = CFG_IMAGE_WIDTH;
		val[0] = CFG_DATA_W'(fmt);
		val[1] = CFG_DATA_W'(trans);
		val[2] = width;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid  <= 1'b0;
		cfg_format = fmt;
		cfg_trans  = trans;
		cfg_width  = width;
	endtask

	// Straight after reset: zero and all-ones blocks under the reset settings.
	// The all-ones block sits in the far corner, so its addresses wrap.
	task automatic test_reset_settings;
		send_block(64'h0, 64'h0, 12'd0, 12'd0);
		send_block('1, '1, 12'd4095, 12'd4095);
	endtask

	// DXT1 in both palette modes, with and without the transparent index.
	// Index pattern E4 walks through all four palette entries on every row.
	task automatic test_dxt1;
		set_config(FMT_DXT1, 1'b1, 13'd4096);
		send_block({32'hE4E4E4E4, 16'hF800, 16'h001F}, 64'h0, 12'd0, 12'd4);
		send_block({32'hE4E4E4E4, 16'h07E0, 16'hF800}, 64'h0, 12'd8, 12'd0);
		send_block({32'hFFFFFFFF, 16'h1234, 16'h1234}, '1, 12'd4, 12'd4);
		set_config(FMT_DXT1, 1'b0, 13'd4096);
		send_block({32'h1B1B1B1B, 16'hFFFF, 16'h0000}, 64'h0, 12'd16, 12'd16);
	endtask

	// DXT3: a ramp of explicit alphas, solid and empty alpha, and the
	// transparent index overriding the explicit value.
	task automatic test_dxt3;
		set_config(FMT_DXT3, 1'b1, 13'd4096);
		send_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, 64'hFEDCBA9876543210, 12'd0, 12'd0);
		send_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, '1, 12'd4, 12'd0);
		send_block({32'h5555AAAA, 16'h8410, 16'h7BEF}, 64'h0, 12'd0, 12'd8);
		set_config(FMT_DXT3, 1'b0, 13'd4096);
		send_block({32'hFFFF0000, 16'hF81F, 16'h07E0}, 64'h0123456789ABCDEF, 12'd12, 12'd12);
	endtask

	// DXT5: both alpha table modes, equal alphas, and a low endpoint first,
	// which still gives four colours. The indices run 0 to 7 twice.
	task automatic test_dxt5;
		set_config(FMT_DXT5, 1'b1, 13'd4096);
		send_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, {48'hFAC688FAC688, 8'h00, 8'hFF},
			12'd0, 12'd0);
		send_block({32'hFFFFFFFF, 16'hFFFF, 16'h0000}, {48'hFAC688FAC688, 8'hFF, 8'h00},
			12'd4, 12'd0);
		send_block({32'h1B1B1B1B, 16'h1234, 16'h1234}, {48'hFAC688FAC688, 8'h80, 8'h80},
			12'd8, 12'd0);
		send_block('1, '1, 12'd4092, 12'd4092);
	endtask

	// Narrowest stride, then strides above the maximum, which are clamped.
	task automatic test_stride;
		set_config(FMT_DXT1, 1'b0, 13'd4);
		send_block({32'hE4E4E4E4, 16'hABCD, 16'hDCBA}, 64'h0, 12'd0, 12'd4095);
		set_config(FMT_DXT3, 1'b1, 13'd8191);
		send_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, 64'hF0F0F0F00F0F0F0F,
			12'd4095, 12'd4095);
		set_config(FMT_DXT5, 1'b0, 13'd4097);
		send_block({32'h0, 16'h0000, 16'hFFFF}, {48'h0, 8'h10, 8'hF0}, 12'd100, 12'd200);
	endtask

	// The spare format code must behave as DXT1, alpha part ignored.
	task automatic test_spare_format;
		set_config(FMT_SPARE, 1'b1, 13'd64);
		send_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, 64'h0123456789ABCDEF, 12'd60, 12'd3);
		send_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, '1, 12'd0, 12'd0);
	endtask

	// Random blocks under several random settings. Every block is well formed;
	// equal endpoints and equal alphas are forced now and then so that the
	// three-colour and six-alpha paths get their share.
	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		logic [63:0] cb;
		logic [63:0] ab;
		logic [12:0] width;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int chunk = 0; chunk < 4; chunk++) begin
			case ($urandom_range(3))
				0: width = 13'd4;
				1: width = 13'd4096;
				2: width = 13'($urandom_range(4096, 4));
				default: width = 13'($urandom_range(8191, 4097));
			endcase
			set_config(2'($urandom_range(3)), 1'($urandom_range(1)), width);
			for (int n = 0; n < 40; n++) begin
				cb = {$urandom, $urandom};
				ab = {$urandom, $urandom};
				if ($urandom_range(3) == 0) cb[31:16] = cb[15:0];
				if ($urandom_range(3) == 0) ab[15:8] = ab[7:0];
				if ($urandom_range(7) == 0) ab[7:0] = $urandom_range(1) ? 8'hFF : 8'h00;
				// Now and then hold off until the block has emptied completely.
				if ($urandom_range(39) == 0) drain();
				send_block(cb, ab, 12'($urandom), 12'($urandom));
			end
		end
	endtask

	// Receiver: random back-pressure, and every pixel taken is checked against
	// the oldest owed pixel.
	always @(posedge clk) begin
		pixel_t want;
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t ns: unexpected pixel, rgba %h address %h", $time,
					pixel_rgba, pixel_address);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				compare_field("pixel_rgba", want.rgba, pixel_rgba);
				compare_field("pixel_address", 32'(want.addr), 32'(pixel_address));
				compare_field("last_pixel", 32'(want.last), 32'(last_pixel));
				compare_field("zero_alpha_seen", 32'(want.zero), 32'(zero_alpha_seen));
				compare_field("partial_alpha_seen", 32'(want.part), 32'(partial_alpha_seen));
			end
		end
	end

	// Watchdog: a run of cycles in which no request moves on any channel
	// means the block has hung.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_dxt1();
		test_dxt3();
		test_dxt5();
		test_stride();
		test_spare_format();
		test_random_traffic(16, 83);
		test_random_traffic(83, 16);
		test_random_traffic(0, 0);
		drain();
		// Give any stray pixel time to show itself.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
